@@ design/thrust_curve_interpolator_defines.svh @@
// Assertion macros for the checker file of the thrust curve interpolator
`ifndef THRUST_CURVE_INTERPOLATOR_DEFINES_SVH
`define THRUST_CURVE_INTERPOLATOR_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define TCI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define TCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/tci_pkg.sv @@
// Shared types, constants and the breakpoint table of the thrust curve interpolator
package tci_pkg;

    localparam int TABLE_LEN        = 37;
    localparam int CURVE_POINTS_DEF = 37;
    localparam int IDX_W            = $clog2(TABLE_LEN);

    localparam int TIME_W     = 32;
    localparam int THRUST_W   = 22;
    localparam int MASS_W     = 23;
    localparam int TOTAL_W    = 30;
    localparam int DIR_W      = 16;
    localparam int FORCE_W    = 23;
    localparam int FRAC_SHIFT = 16;
    localparam int FRAC_W     = FRAC_SHIFT + 1;
    localparam int SEG_W      = 17;
    localparam int DIR_SHIFT  = 15;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TOTAL_W-1:0]      TOTAL_MAX     = '1;
    localparam logic [TOTAL_W-1:0]      MASS_FLOOR_MG = 30'd2235000;
    localparam logic [TOTAL_W-1:0]      UNLOADED_RST  = '0;
    localparam logic signed [DIR_W-1:0] DIR_X_RST     = 16'sd32767;
    localparam logic signed [DIR_W-1:0] DIR_Y_RST     = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_Z_RST     = 16'sd0;

    typedef enum logic [1:0] {
        REG_UNLOADED,
        REG_DIR_X,
        REG_DIR_Y,
        REG_DIR_Z
    } tci_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV,
        ST_LERP,
        ST_FORCE_GO,
        ST_FORCE,
        ST_DONE
    } tci_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tci_stat_t;

    typedef struct packed {
        logic [TIME_W-1:0]   t_us;
        logic [THRUST_W-1:0] thrust;
        logic [MASS_W-1:0]   mass;
    } tci_point_t;

    function automatic tci_point_t curve_point(input logic [IDX_W-1:0] idx);
        tci_point_t p;
        unique case (idx)
            6'd0:    p = '{32'd11000,   22'd1195177, 23'd4751000};
            6'd1:    p = '{32'd24000,   22'd2029903, 23'd4740653};
            6'd2:    p = '{32'd37000,   22'd2380868, 23'd4726503};
            6'd3:    p = '{32'd50000,   22'd2542122, 23'd4710709};
            6'd4:    p = '{32'd100000,  22'd2570578, 23'd4647622};
            6'd5:    p = '{32'd150000,  22'd2561093, 23'd4584301};
            6'd6:    p = '{32'd200000,  22'd2523151, 23'd4521565};
            6'd7:    p = '{32'd250000,  22'd2485208, 23'd4459766};
            6'd8:    p = '{32'd300000,  22'd2523151, 23'd4397967};
            6'd9:    p = '{32'd350000,  22'd2570578, 23'd4335114};
            6'd10:   p = '{32'd400000,  22'd2674919, 23'd4270389};
            6'd11:   p = '{32'd500000,  22'd2912057, 23'd4132511};
            6'd12:   p = '{32'd600000,  22'd3073311, 23'd3984801};
            6'd13:   p = '{32'd700000,  22'd3073311, 23'd3833112};
            6'd14:   p = '{32'd800000,  22'd3101768, 23'd3680720};
            6'd15:   p = '{32'd900000,  22'd3092282, 23'd3527860};
            6'd16:   p = '{32'd1000000, 22'd3092282, 23'd3375235};
            6'd17:   p = '{32'd1100000, 22'd2959485, 23'd3225887};
            6'd18:   p = '{32'd1186000, 22'd2807716, 23'd3103486};
            6'd19:   p = '{32'd1227000, 22'd2437781, 23'd3050412};
            6'd20:   p = '{32'd1270000, 22'd2257556, 23'd3000586};
            6'd21:   p = '{32'd1300000, 22'd2162701, 23'd2967860};
            6'd22:   p = '{32'd1400000, 22'd1991961, 23'd2865330};
            6'd23:   p = '{32'd1500000, 22'd1878135, 23'd2769822};
            6'd24:   p = '{32'd1600000, 22'd1792765, 23'd2679229};
            6'd25:   p = '{32'd1700000, 22'd1688424, 23'd2593319};
            6'd26:   p = '{32'd1800000, 22'd1612540, 23'd2511856};
            6'd27:   p = '{32'd1900000, 22'd1584083, 23'd2432968};
            6'd28:   p = '{32'd2000000, 22'd1536656, 23'd2355953};
            6'd29:   p = '{32'd2048000, 22'd1498714, 23'd2319997};
            6'd30:   p = '{32'd2084000, 22'd1403858, 23'd2294210};
            6'd31:   p = '{32'd2102000, 22'd1166720, 23'd2282791};
            6'd32:   p = '{32'd2134000, 22'd796784,  23'd2267285};
            6'd33:   p = '{32'd2186000, 22'd455305,  23'd2251218};
            6'd34:   p = '{32'd2237000, 22'd237138,  23'd2242503};
            6'd35:   p = '{32'd2300000, 22'd94855,   23'd2237341};
            6'd36:   p = '{32'd2400000, 22'd0,       23'd2235000};
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

@@ design/tci_if.sv @@
// Valid/ready channel interfaces for time stamps in and curve results out
interface tci_in_if;
    logic                         valid;
    logic                         ready;
    logic [tci_pkg::TIME_W-1:0]   time_us;

    modport source (output valid, output time_us, input ready);
    modport sink   (input valid, input time_us, output ready);
endinterface

interface tci_out_if;
    logic                                valid;
    logic                                ready;
    logic [tci_pkg::THRUST_W-1:0]        thrust_mn;
    logic [tci_pkg::TOTAL_W-1:0]         total_mass_mg;
    logic signed [tci_pkg::FORCE_W-1:0]  force_x_mn;
    logic signed [tci_pkg::FORCE_W-1:0]  force_y_mn;
    logic signed [tci_pkg::FORCE_W-1:0]  force_z_mn;

    modport source (output valid, output thrust_mn, output total_mass_mg,
                    output force_x_mn, output force_y_mn, output force_z_mn, input ready);
    modport sink   (input valid, input thrust_mn, input total_mass_mg,
                    input force_x_mn, input force_y_mn, input force_z_mn, output ready);
endinterface

@@ design/thrust_curve_interpolator.sv @@
// Top level of the thrust curve interpolator: APB registers, sequencer and serial datapath
//
// Each time stamp produces one result with thrust, total mass and the force vector.
// Inside the curve the segment search visits one breakpoint per cycle, the fraction comes
// from a bit-serial divider (17 steps), the interpolation from two bit-serial multipliers
// (17 steps) and the force vector from three more (22 steps). Before the first or after
// the last point an item skips the divider and the interpolation. One item is worked on
// at a time; the next time stamp is taken in the cycle after the result moves to the
// output register, even while that result waits.
module thrust_curve_interpolator #(
    parameter int CURVE_POINTS = tci_pkg::CURVE_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tci_pkg::ADDR_W-1:0]    paddr,
    input  logic [tci_pkg::DATA_W-1:0]    pwdata,
    output logic [tci_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    tci_in_if.sink                        in_ch,
    tci_out_if.source                     out_ch
);

    localparam int CURVE_N = (CURVE_POINTS < 2) ? 2 :
                             ((CURVE_POINTS > tci_pkg::TABLE_LEN) ? tci_pkg::TABLE_LEN
                                                                  : CURVE_POINTS);
    localparam logic [tci_pkg::IDX_W-1:0] LAST_IDX = tci_pkg::IDX_W'(CURVE_N - 1);
    localparam int TPW = tci_pkg::FRAC_W + tci_pkg::THRUST_W + 1;
    localparam int MPW = tci_pkg::FRAC_W + tci_pkg::MASS_W + 1;
    localparam int FPW = tci_pkg::THRUST_W + tci_pkg::DIR_W;
    localparam int TSW = TPW - tci_pkg::FRAC_SHIFT;
    localparam int MSW = MPW - tci_pkg::FRAC_SHIFT;

    // configuration registers
    logic [tci_pkg::TOTAL_W-1:0]      unloaded_reg;
    logic signed [tci_pkg::DIR_W-1:0] dir_x_reg;
    logic signed [tci_pkg::DIR_W-1:0] dir_y_reg;
    logic signed [tci_pkg::DIR_W-1:0] dir_z_reg;
    logic                             cfg_wr;
    tci_pkg::tci_reg_t                cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_sel = tci_pkg::tci_reg_t'(paddr[tci_pkg::ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unloaded_reg <= tci_pkg::UNLOADED_RST;
            dir_x_reg    <= tci_pkg::DIR_X_RST;
            dir_y_reg    <= tci_pkg::DIR_Y_RST;
            dir_z_reg    <= tci_pkg::DIR_Z_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                tci_pkg::REG_UNLOADED: unloaded_reg <= pwdata[tci_pkg::TOTAL_W-1:0];
                tci_pkg::REG_DIR_X:    dir_x_reg    <= $signed(pwdata[tci_pkg::DIR_W-1:0]);
                tci_pkg::REG_DIR_Y:    dir_y_reg    <= $signed(pwdata[tci_pkg::DIR_W-1:0]);
                tci_pkg::REG_DIR_Z:    dir_z_reg    <= $signed(pwdata[tci_pkg::DIR_W-1:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            tci_pkg::REG_UNLOADED:
                prdata = tci_pkg::DATA_W'(unloaded_reg);
            tci_pkg::REG_DIR_X:
                prdata = tci_pkg::DATA_W'($unsigned(dir_x_reg));
            tci_pkg::REG_DIR_Y:
                prdata = tci_pkg::DATA_W'($unsigned(dir_y_reg));
            tci_pkg::REG_DIR_Z:
                prdata = tci_pkg::DATA_W'($unsigned(dir_z_reg));
        endcase
    end

    // sequencer and working registers
    tci_pkg::tci_state_t              state_reg, state_next;
    logic [tci_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                             below_reg, below_next;
    logic                             above_reg, above_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tci_pkg::TIME_W-1:0]       time_reg;
    logic [tci_pkg::THRUST_W-1:0]     thrust_reg;
    logic [tci_pkg::MASS_W-1:0]       mass_reg;

    logic [tci_pkg::THRUST_W-1:0]     out_thrust_reg;
    logic [tci_pkg::TOTAL_W-1:0]      out_total_reg;
    logic signed [tci_pkg::FORCE_W-1:0] out_fx_reg;
    logic signed [tci_pkg::FORCE_W-1:0] out_fy_reg;
    logic signed [tci_pkg::FORCE_W-1:0] out_fz_reg;

    tci_pkg::tci_point_t              prev_pt;
    tci_pkg::tci_point_t              cur_pt;
    tci_pkg::tci_point_t              first_pt;
    tci_pkg::tci_point_t              last_pt;

    logic                             in_ready;
    logic                             in_fire;
    logic                             out_free;
    logic                             outside;
    logic                             search_more;
    logic                             search_step;
    logic                             edge_load;
    logic                             div_start;
    logic                             lerp_start;
    logic                             lerp_load;
    logic                             force_start;
    logic                             out_load;
    logic                             lerp_done;
    logic                             force_done;
    logic                             units_busy;

    logic [tci_pkg::TIME_W-1:0]       dt_full;
    logic [tci_pkg::TIME_W-1:0]       seg_full;
    logic [tci_pkg::FRAC_W-1:0]       frac;
    logic signed [tci_pkg::THRUST_W:0] thr_delta;
    logic signed [tci_pkg::MASS_W:0]  mass_delta;
    logic signed [TPW-1:0]            thr_prod;
    logic signed [MPW-1:0]            mass_prod;
    logic signed [TSW-1:0]            thr_sum;
    logic signed [MSW-1:0]            mass_sum;
    logic signed [FPW-1:0]            fx_prod;
    logic signed [FPW-1:0]            fy_prod;
    logic signed [FPW-1:0]            fz_prod;
    logic [tci_pkg::TOTAL_W:0]        total_sum;
    logic [tci_pkg::TOTAL_W-1:0]      total_sat;

    tci_pkg::tci_stat_t               div_stat;
    tci_pkg::tci_stat_t               thr_stat;
    tci_pkg::tci_stat_t               mass_stat;
    tci_pkg::tci_stat_t               fx_stat;
    tci_pkg::tci_stat_t               fy_stat;
    tci_pkg::tci_stat_t               fz_stat;

    assign prev_pt  = tci_pkg::curve_point(idx_reg - tci_pkg::IDX_W'(1));
    assign cur_pt   = tci_pkg::curve_point(idx_reg);
    assign first_pt = tci_pkg::curve_point('0);
    assign last_pt  = tci_pkg::curve_point(LAST_IDX);

    assign in_fire     = in_ch.valid & in_ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign outside     = below_reg | above_reg;
    assign search_more = (idx_reg < LAST_IDX) && (time_reg > cur_pt.t_us);
    assign lerp_done   = thr_stat.done & mass_stat.done;
    assign force_done  = fx_stat.done & fy_stat.done & fz_stat.done;
    assign units_busy  = div_stat.busy | thr_stat.busy | mass_stat.busy |
                         fx_stat.busy | fy_stat.busy | fz_stat.busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tci_pkg::ST_IDLE:
                if (in_fire)
                    state_next = tci_pkg::ST_SEARCH;
            tci_pkg::ST_SEARCH:
                priority if (outside)
                    state_next = tci_pkg::ST_FORCE_GO;
                else if (!search_more)
                    state_next = tci_pkg::ST_DIV;
                else
                    state_next = tci_pkg::ST_SEARCH;
            tci_pkg::ST_DIV:
                if (div_stat.done)
                    state_next = tci_pkg::ST_LERP;
            tci_pkg::ST_LERP:
                if (lerp_done)
                    state_next = tci_pkg::ST_FORCE_GO;
            tci_pkg::ST_FORCE_GO:
                state_next = tci_pkg::ST_FORCE;
            tci_pkg::ST_FORCE:
                if (force_done)
                    state_next = tci_pkg::ST_DONE;
            tci_pkg::ST_DONE:
                if (out_free)
                    state_next = tci_pkg::ST_IDLE;
            default:
                state_next = tci_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        search_step = 1'b0;
        edge_load   = 1'b0;
        div_start   = 1'b0;
        lerp_start  = 1'b0;
        lerp_load   = 1'b0;
        force_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            tci_pkg::ST_IDLE:
                in_ready = !units_busy;
            tci_pkg::ST_SEARCH:
            begin
                edge_load   = outside;
                search_step = !outside && search_more;
                div_start   = !outside && !search_more;
            end
            tci_pkg::ST_DIV:
                lerp_start = div_stat.done;
            tci_pkg::ST_LERP:
                lerp_load = lerp_done;
            tci_pkg::ST_FORCE_GO:
                force_start = 1'b1;
            tci_pkg::ST_FORCE:
                ;
            tci_pkg::ST_DONE:
                out_load = out_free;
            default:
                ;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        below_next     = below_reg;
        above_next     = above_reg;
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            idx_next   = tci_pkg::IDX_W'(1);
            below_next = in_ch.time_us < first_pt.t_us;
            above_next = in_ch.time_us > last_pt.t_us;
        end
        else if (search_step)
            idx_next = idx_reg + tci_pkg::IDX_W'(1);
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tci_pkg::ST_IDLE;
            idx_reg       <= tci_pkg::IDX_W'(1);
            below_reg     <= 1'b0;
            above_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            below_reg     <= below_next;
            above_reg     <= above_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // serial datapath
    assign dt_full    = time_reg - prev_pt.t_us;
    assign seg_full   = cur_pt.t_us - prev_pt.t_us;
    assign thr_delta  = $signed({1'b0, cur_pt.thrust}) - $signed({1'b0, prev_pt.thrust});
    assign mass_delta = $signed({1'b0, cur_pt.mass}) - $signed({1'b0, prev_pt.mass});

    tci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dt_full[tci_pkg::SEG_W-1:0]),
        .divisor  (seg_full[tci_pkg::SEG_W-1:0]),
        .stat     (div_stat),
        .quotient (frac)
    );

    tci_sermul #(.MW(tci_pkg::FRAC_W), .AW(tci_pkg::THRUST_W + 1)) u_mul_thr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .m     (frac),
        .a     (thr_delta),
        .stat  (thr_stat),
        .prod  (thr_prod)
    );

    tci_sermul #(.MW(tci_pkg::FRAC_W), .AW(tci_pkg::MASS_W + 1)) u_mul_mass (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lerp_start),
        .m     (frac),
        .a     (mass_delta),
        .stat  (mass_stat),
        .prod  (mass_prod)
    );

    tci_sermul #(.MW(tci_pkg::THRUST_W), .AW(tci_pkg::DIR_W)) u_mul_fx (
        .clk   (clk),
        .rst_n (rst_n),
        .start (force_start),
        .m     (thrust_reg),
        .a     (dir_x_reg),
        .stat  (fx_stat),
        .prod  (fx_prod)
    );

    tci_sermul #(.MW(tci_pkg::THRUST_W), .AW(tci_pkg::DIR_W)) u_mul_fy (
        .clk   (clk),
        .rst_n (rst_n),
        .start (force_start),
        .m     (thrust_reg),
        .a     (dir_y_reg),
        .stat  (fy_stat),
        .prod  (fy_prod)
    );

    tci_sermul #(.MW(tci_pkg::THRUST_W), .AW(tci_pkg::DIR_W)) u_mul_fz (
        .clk   (clk),
        .rst_n (rst_n),
        .start (force_start),
        .m     (thrust_reg),
        .a     (dir_z_reg),
        .stat  (fz_stat),
        .prod  (fz_prod)
    );

    // floor of the product over 2^16 added to the segment's start value
    assign thr_sum  = $signed({{(TSW - tci_pkg::THRUST_W){1'b0}}, prev_pt.thrust}) +
                      $signed(thr_prod[TPW-1:tci_pkg::FRAC_SHIFT]);
    assign mass_sum = $signed({{(MSW - tci_pkg::MASS_W){1'b0}}, prev_pt.mass}) +
                      $signed(mass_prod[MPW-1:tci_pkg::FRAC_SHIFT]);

    assign total_sum = {1'b0, unloaded_reg} + (tci_pkg::TOTAL_W + 1)'(mass_reg);
    assign total_sat = total_sum[tci_pkg::TOTAL_W] ? tci_pkg::TOTAL_MAX
                                                   : total_sum[tci_pkg::TOTAL_W-1:0];

    always_ff @(posedge clk)
    begin
        if (in_fire)
            time_reg <= in_ch.time_us;
        if (edge_load)
        begin
            thrust_reg <= '0;
            mass_reg   <= below_reg ? first_pt.mass : last_pt.mass;
        end
        else if (lerp_load)
        begin
            thrust_reg <= thr_sum[tci_pkg::THRUST_W-1:0];
            mass_reg   <= mass_sum[tci_pkg::MASS_W-1:0];
        end
        if (out_load)
        begin
            out_thrust_reg <= thrust_reg;
            out_total_reg  <= total_sat;
            out_fx_reg     <= fx_prod[FPW-1:tci_pkg::DIR_SHIFT];
            out_fy_reg     <= fy_prod[FPW-1:tci_pkg::DIR_SHIFT];
            out_fz_reg     <= fz_prod[FPW-1:tci_pkg::DIR_SHIFT];
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.thrust_mn     = out_thrust_reg;
    assign out_ch.total_mass_mg = out_total_reg;
    assign out_ch.force_x_mn    = out_fx_reg;
    assign out_ch.force_y_mn    = out_fy_reg;
    assign out_ch.force_z_mn    = out_fz_reg;

endmodule

@@ design/tci_div.sv @@
// Bit-serial restoring divider for the Q1.16 segment fraction
module tci_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tci_pkg::SEG_W-1:0]   dividend,
    input  logic [tci_pkg::SEG_W-1:0]   divisor,
    output tci_pkg::tci_stat_t          stat,
    output logic [tci_pkg::FRAC_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(tci_pkg::FRAC_W + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic                       first_reg, first_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tci_pkg::SEG_W-1:0]  rem_reg, rem_next;
    logic [tci_pkg::SEG_W-1:0]  dsr_reg, dsr_next;
    logic [tci_pkg::FRAC_W-1:0] quo_reg, quo_next;
    logic [tci_pkg::SEG_W:0]    trial;
    logic [tci_pkg::SEG_W:0]    diff;
    logic                       ge;

    assign trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            cnt_next   = CNT_W'(tci_pkg::FRAC_W);
            rem_next   = dividend;
            dsr_next   = divisor;
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            first_next = 1'b0;
            rem_next   = ge ? diff[tci_pkg::SEG_W-1:0] : trial[tci_pkg::SEG_W-1:0];
            quo_next   = {quo_reg[tci_pkg::FRAC_W-2:0], ge};
            cnt_next   = cnt_reg - CNT_W'(1);
            busy_next  = cnt_reg != CNT_W'(1);
            done_next  = cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ design/tci_sermul.sv @@
// Bit-serial shift-add multiplier: unsigned serial operand times signed parallel operand
module tci_sermul #(
    parameter int MW = tci_pkg::FRAC_W,
    parameter int AW = tci_pkg::THRUST_W + 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [MW-1:0]             m,
    input  logic signed [AW-1:0]      a,
    output tci_pkg::tci_stat_t        stat,
    output logic signed [MW+AW-1:0]   prod
);

    localparam int PW    = MW + AW;
    localparam int CNT_W = $clog2(MW + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MW-1:0]           m_reg, m_next;
    logic signed [AW-1:0]    a_reg, a_next;
    logic signed [PW-1:0]    acc_reg, acc_next;
    logic signed [PW-1:0]    a_ext;
    logic signed [PW-1:0]    addend;

    assign a_ext  = {{MW{a_reg[AW-1]}}, a_reg};
    assign addend = m_reg[MW-1] ? a_ext : '0;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MW);
            m_next    = m;
            a_next    = a;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next  = (acc_reg <<< 1) + addend;
            m_next    = {m_reg[MW-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
            done_next = cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

@@ design/tci_checker.sv @@
// Port-level checker for the thrust curve interpolator and its bind
`include "thrust_curve_interpolator_defines.svh"

module tci_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [tci_pkg::THRUST_W-1:0]        thrust_mn,
    input logic [tci_pkg::TOTAL_W-1:0]         total_mass_mg,
    input logic signed [tci_pkg::FORCE_W-1:0]  force_x_mn,
    input logic signed [tci_pkg::FORCE_W-1:0]  force_y_mn,
    input logic signed [tci_pkg::FORCE_W-1:0]  force_z_mn
);

    `TCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(thrust_mn) && $stable(total_mass_mg), "result dropped while stalled")

    `TCI_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
        "second time stamp taken while one is in work")

    `TCI_ASSERT_SAME(a_zero_force, out_valid && thrust_mn == '0,
        force_x_mn == '0 && force_y_mn == '0 && force_z_mn == '0, "force without thrust")

    `TCI_ASSERT_SAME(a_mass_floor, out_valid, total_mass_mg >= tci_pkg::MASS_FLOOR_MG,
        "total mass below burnout propellant mass")

endmodule

bind thrust_curve_interpolator tci_checker u_tci_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .thrust_mn     (out_ch.thrust_mn),
    .total_mass_mg (out_ch.total_mass_mg),
    .force_x_mn    (out_ch.force_x_mn),
    .force_y_mn    (out_ch.force_y_mn),
    .force_z_mn    (out_ch.force_z_mn)
);

@@ tb/sv/tb_thrust_curve_interpolator.sv @@
// Self-checking testbench for the thrust curve interpolator: APB setup, random time stamps, scoreboard
module tb_thrust_curve_interpolator;

    import tci_pkg::*;

    localparam int POINTS        = (CURVE_POINTS_DEF < 2) ? 2 :
                                   (CURVE_POINTS_DEF > TABLE_LEN) ? TABLE_LEN : CURVE_POINTS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 112;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 120;
    localparam int MAX_GAP       = 13;
    localparam int EDGE_COUNT    = 22;

    localparam int unsigned KNOT_US [37] = '{
        11000, 24000, 37000, 50000, 100000, 150000, 200000, 250000,
        300000, 350000, 400000, 500000, 600000, 700000, 800000, 900000,
        1000000, 1100000, 1186000, 1227000, 1270000, 1300000, 1400000,
        1500000, 1600000, 1700000, 1800000, 1900000, 2000000, 2048000,
        2084000, 2102000, 2134000, 2186000, 2237000, 2300000, 2400000
    };

    localparam int KNOT_MN [37] = '{
        1195177, 2029903, 2380868, 2542122, 2570578, 2561093, 2523151, 2485208,
        2523151, 2570578, 2674919, 2912057, 3073311, 3073311, 3101768, 3092282,
        3092282, 2959485, 2807716, 2437781, 2257556, 2162701, 1991961, 1878135,
        1792765, 1688424, 1612540, 1584083, 1536656, 1498714, 1403858, 1166720,
        796784, 455305, 237138, 94855, 0
    };

    localparam int KNOT_MG [37] = '{
        4751000, 4740653, 4726503, 4710709, 4647622, 4584301, 4521565, 4459766,
        4397967, 4335114, 4270389, 4132511, 3984801, 3833112, 3680720, 3527860,
        3375235, 3225887, 3103486, 3050412, 3000586, 2967860, 2865330, 2769822,
        2679229, 2593319, 2511856, 2432968, 2355953, 2319997, 2294210, 2282791,
        2267285, 2251218, 2242503, 2237341, 2235000
    };

    localparam int unsigned EDGE_TIMES [EDGE_COUNT] = '{
        32'd0, 32'd1, 32'd10999, 32'd11000, 32'd11001, 32'd17500, 32'd24000,
        32'd24001, 32'd800000, 32'd1186000, 32'd1227000, 32'd1299999, 32'd2134000,
        32'd2399999, 32'd2400000, 32'd2400001, 32'h7FFFFFFF, 32'h80000000,
        32'hFFFFFFFE, 32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA
    };

    typedef struct packed {
        logic [THRUST_W-1:0]       thrust_mn;
        logic [TOTAL_W-1:0]        total_mass_mg;
        logic signed [FORCE_W-1:0] force_x_mn;
        logic signed [FORCE_W-1:0] force_y_mn;
        logic signed [FORCE_W-1:0] force_z_mn;
    } curve_sample_t;

    class curve_scoreboard;
        logic [TOTAL_W-1:0]      unloaded_mg;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        curve_sample_t           awaited_samples[$];
        int                      failures;

        function new();
            unloaded_mg = UNLOADED_RST;
            dir_x       = DIR_X_RST;
            dir_y       = DIR_Y_RST;
            dir_z       = DIR_Z_RST;
            failures    = 0;
        endfunction

        function void set_register(tci_reg_t idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_UNLOADED: unloaded_mg = value[TOTAL_W-1:0];
                REG_DIR_X:    dir_x = value[DIR_W-1:0];
                REG_DIR_Y:    dir_y = value[DIR_W-1:0];
                REG_DIR_Z:    dir_z = value[DIR_W-1:0];
                default:      ;
            endcase
        endfunction

        function curve_sample_t interpolate_curve(logic [TIME_W-1:0] t_us);
            longint        thrust;
            longint        mass;
            longint        total;
            longint        seg;
            longint        dt;
            longint        frac;
            int            k;
            curve_sample_t s;
            thrust = 0;
            if (t_us < KNOT_US[0])
                mass = KNOT_MG[0];
            else if (t_us > KNOT_US[POINTS-1])
                mass = KNOT_MG[POINTS-1];
            else
            begin
                k = 1;
                while (k < POINTS - 1 && t_us > KNOT_US[k])
                    k++;
                seg    = longint'(KNOT_US[k]) - longint'(KNOT_US[k-1]);
                dt     = longint'(t_us) - longint'(KNOT_US[k-1]);
                frac   = (dt << FRAC_SHIFT) / seg;
                thrust = KNOT_MN[k-1] + ((frac * (KNOT_MN[k] - KNOT_MN[k-1])) >>> FRAC_SHIFT);
                mass   = KNOT_MG[k-1] + ((frac * (KNOT_MG[k] - KNOT_MG[k-1])) >>> FRAC_SHIFT);
            end
            total = mass + longint'({34'b0, unloaded_mg});
            if (total > longint'({34'b0, TOTAL_MAX}))
                total = longint'({34'b0, TOTAL_MAX});
            s.thrust_mn     = THRUST_W'(thrust);
            s.total_mass_mg = TOTAL_W'(total);
            s.force_x_mn    = FORCE_W'((thrust * longint'(dir_x)) >>> DIR_SHIFT);
            s.force_y_mn    = FORCE_W'((thrust * longint'(dir_y)) >>> DIR_SHIFT);
            s.force_z_mn    = FORCE_W'((thrust * longint'(dir_z)) >>> DIR_SHIFT);
            return s;
        endfunction

        function void note_time(logic [TIME_W-1:0] t_us);
            awaited_samples.push_back(interpolate_curve(t_us));
        endfunction

        function void check_result(curve_sample_t got);
            curve_sample_t want;
            if (awaited_samples.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: thrust %0d mass %0d force %0d %0d %0d",
                             got.thrust_mn, got.total_mass_mg,
                             got.force_x_mn, got.force_y_mn, got.force_z_mn);
                return;
            end
            want = awaited_samples.pop_front();
            if (got.thrust_mn !== want.thrust_mn || got.total_mass_mg !== want.total_mass_mg ||
                got.force_x_mn !== want.force_x_mn || got.force_y_mn !== want.force_y_mn ||
                got.force_z_mn !== want.force_z_mn)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch: expected thrust %0d mass %0d force %0d %0d %0d",
                             want.thrust_mn, want.total_mass_mg,
                             want.force_x_mn, want.force_y_mn, want.force_z_mn);
                    $display("          actual   thrust %0d mass %0d force %0d %0d %0d",
                             got.thrust_mn, got.total_mass_mg,
                             got.force_x_mn, got.force_y_mn, got.force_z_mn);
                end
            end
        endfunction

        function int outstanding();
            return awaited_samples.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tci_in_if  in_ch ();
    tci_out_if out_ch ();

    curve_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    int rx_hold     = 0;
    int cycle_count = 0;

    thrust_curve_interpolator DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            sb.note_time(in_ch.time_us);
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{out_ch.thrust_mn, out_ch.total_mass_mg,
                              out_ch.force_x_mn, out_ch.force_y_mn, out_ch.force_z_mn});
    end

    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            if (rx_hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    task automatic write_register(tci_reg_t idx, logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic apply_setting(logic [TOTAL_W-1:0] unloaded, logic [DIR_W-1:0] dx,
                                 logic [DIR_W-1:0] dy, logic [DIR_W-1:0] dz);
        write_register(REG_UNLOADED, DATA_W'(unloaded));
        write_register(REG_DIR_X, DATA_W'(dx));
        write_register(REG_DIR_Y, DATA_W'(dy));
        write_register(REG_DIR_Z, DATA_W'(dz));
    endtask

    // hold valid high across back-to-back transfers
    task automatic send_time(logic [TIME_W-1:0] t_us);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.time_us <= t_us;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() > 0);
    endtask

    function automatic logic [TIME_W-1:0] draw_time();
        int          pick;
        int          k;
        int unsigned t;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            t = $urandom_range(KNOT_US[POINTS-1], KNOT_US[0]);
        else if (pick < 75)
        begin
            k = $urandom_range(0, POINTS - 1);
            t = KNOT_US[k] + $urandom_range(0, 2) - 1;
        end
        else if (pick < 83)
            t = $urandom_range(0, KNOT_US[0] - 1);
        else if (pick < 91)
            t = $urandom_range(32'hFFFFFFFF, KNOT_US[POINTS-1] + 1);
        else
            t = $urandom();
        return t;
    endfunction

    initial
    begin
        int phase;
        int item;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.time_us <= '0;
        rst_n         <= 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (item = 0; item < EDGE_COUNT; item++)
            send_time(EDGE_TIMES[item]);
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            repeat (4) @(posedge clk);
            case (phase)
                0:       apply_setting(30'd1000000000, 16'h8000, 16'h7FFF, 16'h8000);
                1:       apply_setting(TOTAL_MAX, 16'h0000, 16'h8000, 16'h7FFF);
                2:       apply_setting(TOTAL_MAX - 30'd3000000, 16'hFFFF, 16'h0001, 16'd23170);
                3:       apply_setting('0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                default: apply_setting(($urandom_range(0, 3) == 0) ?
                                       TOTAL_W'($urandom_range(TOTAL_MAX, 1000000000)) :
                                       TOTAL_W'($urandom_range(0, 1000000000)),
                                       DIR_W'($urandom_range(0, 65535)),
                                       DIR_W'($urandom_range(0, 65535)),
                                       DIR_W'($urandom_range(0, 65535)));
            endcase
            tx_idle = (phase % 4 == 0) || (phase % 4 == 1);
            rx_idle = (phase % 4 == 0) || (phase % 4 == 2);
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                if (phase == 2 && item == 20)
                    rx_hold = LONG_HOLD;
                if (phase == 5 && item == 50)
                    wait_for_results();
                send_time(draw_time());
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tci_pkg.sv
design/tci_if.sv
design/tci_div.sv
design/tci_sermul.sv
design/thrust_curve_interpolator.sv
design/tci_checker.sv
tb/sv/tb_thrust_curve_interpolator.sv
